// ===== rtl/ulcp_pkg.sv =====
// Shared types, constants and character helpers for the LED command parser.
// No dependencies; every rtl module imports this package.
package ulcp_pkg;

   localparam int SEQ_DEPTH   = 20;
   localparam int TIME_DEPTH  = 10;
   localparam int STORE_DEPTH = ((SEQ_DEPTH > TIME_DEPTH) ? SEQ_DEPTH : TIME_DEPTH) - 1;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

   localparam logic [FILL_W-1:0] TIME_LIMIT = FILL_W'(TIME_DEPTH - 1);
   localparam logic [FILL_W-1:0] SEQ_LIMIT  = FILL_W'(SEQ_DEPTH - 1);

   localparam int TIME_DIGITS = 6;
   localparam int DIGIT_IDX_W = 3;
   localparam int SECS_W      = 17;
   localparam int DEC_DIGITS  = 5;
   localparam int DEC_IDX_W   = 3;
   localparam int CONV_CNT_W  = $clog2(SECS_W);
   localparam int HMS_W       = 7;

   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int JQ_PTR_W        = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int JQ_CNT_W        = $clog2(JOB_QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_R_UP  = 8'h52;
   localparam logic [7:0] CH_R_LO  = 8'h72;
   localparam logic [7:0] CH_Y_UP  = 8'h59;
   localparam logic [7:0] CH_Y_LO  = 8'h79;
   localparam logic [7:0] CH_G_UP  = 8'h47;
   localparam logic [7:0] CH_G_LO  = 8'h67;
   localparam logic [7:0] CH_T_UP  = 8'h54;
   localparam logic [7:0] CH_T_LO  = 8'h74;
   localparam logic [7:0] CH_S_UP  = 8'h53;
   localparam logic [7:0] CH_S_LO  = 8'h73;
   localparam logic [7:0] CH_D_UP  = 8'h44;
   localparam logic [7:0] CH_D_LO  = 8'h64;

   localparam logic [HMS_W-1:0]  MAX_HOURS       = 7'd23;
   localparam logic [HMS_W-1:0]  MAX_MINUTES     = 7'd59;
   localparam logic [SECS_W-1:0] SECS_PER_HOUR   = 17'd3600;
   localparam logic [SECS_W-1:0] SECS_PER_MINUTE = 17'd60;
   localparam logic [HMS_W-1:0]  DECIMAL_BASE    = 7'd10;
   localparam logic [3:0]        FAIL_DIGIT      = 4'd1;
   localparam logic [3:0]        RANGE_DIGIT     = 4'd3;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TIME = 2'd1,
      MODE_SEQ  = 2'd2,
      MODE_DUR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      COLOR_RED    = 2'd0,
      COLOR_YELLOW = 2'd1,
      COLOR_GREEN  = 2'd2
   } color_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_COLOR = 2'd1,
      KIND_TIMER = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      JOB_COLOR = 2'd0,
      JOB_FAIL  = 2'd1,
      JOB_TIME  = 2'd2,
      JOB_SEQ   = 2'd3
   } job_op_type;

   typedef enum logic [3:0] {
      B_IDLE  = 4'd0,
      B_SPLIT = 4'd1,
      B_SCALE = 4'd2,
      B_CONV  = 4'd3,
      B_NEG   = 4'd4,
      B_DIG   = 4'd5,
      B_X     = 4'd6,
      B_TIMER = 4'd7,
      B_COLOR = 4'd8,
      B_ONE   = 4'd9
   } back_state_type;

   typedef struct packed {
      job_op_type                    op;
      color_type                     color;
      logic [TIME_DIGITS-1:0][3:0]   digits;
      logic [FILL_W-1:0]             seq_len;
      logic [STORE_DEPTH-1:0][1:0]   seq_colors;
   } job_type;

   function automatic logic is_color(input logic [7:0] c);
      return (c == CH_R_UP) || (c == CH_R_LO) || (c == CH_Y_UP) || (c == CH_Y_LO) ||
             (c == CH_G_UP) || (c == CH_G_LO);
   endfunction

   function automatic color_type color_code(input logic [7:0] c);
      color_type code;
      code = COLOR_RED;
      if ((c == CH_Y_UP) || (c == CH_Y_LO)) code = COLOR_YELLOW;
      if ((c == CH_G_UP) || (c == CH_G_LO)) code = COLOR_GREEN;
      return code;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

// ===== rtl/ulcp_front.sv =====
// Front end: byte-level command decoder, buffering and on-the-fly validation.
// Depends on ulcp_pkg; issues at most one job per accepted byte into the job queue.
module ulcp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output logic             job_push,
   output ulcp_pkg::job_type job
);
   import ulcp_pkg::*;

   mode_type                    mode_ff, mode_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [FILL_W-1:0]           text_len_ff, text_len_in;
   logic                        zero_seen_ff, zero_seen_in;
   logic                        bad_ff, bad_in;
   logic [STORE_DEPTH-1:0][1:0] colors_ff;
   logic [TIME_DIGITS-1:0][3:0] digits_ff;

   logic is_x;
   logic is_start;
   logic has_room;
   logic buffering;
   logic store_en;
   logic in_text;
   logic digit_wr;
   logic color_wr;

   assign is_x      = (rx_byte == CH_X);
   assign is_start  = (rx_byte == CH_T_UP) || (rx_byte == CH_T_LO) ||
                      (rx_byte == CH_S_UP) || (rx_byte == CH_S_LO);
   assign buffering = (mode_ff == MODE_TIME) || (mode_ff == MODE_SEQ);
   assign has_room  = (mode_ff == MODE_TIME) ? (fill_ff < TIME_LIMIT) : (fill_ff < SEQ_LIMIT);
   assign store_en  = byte_valid && buffering && !is_x && has_room;
   assign in_text   = !zero_seen_ff && (rx_byte != CH_NUL);
   assign digit_wr  = store_en && in_text && (mode_ff == MODE_TIME) &&
                      (text_len_ff < FILL_W'(TIME_DIGITS));
   assign color_wr  = store_en && (mode_ff == MODE_SEQ);

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (byte_valid) begin
         case (mode_ff)
            MODE_IDLE: begin
               if ((rx_byte == CH_T_UP) || (rx_byte == CH_T_LO)) mode_in = MODE_TIME;
               else if ((rx_byte == CH_S_UP) || (rx_byte == CH_S_LO)) mode_in = MODE_SEQ;
               else if ((rx_byte == CH_D_UP) || (rx_byte == CH_D_LO)) mode_in = MODE_DUR;
            end
            MODE_TIME, MODE_SEQ: begin
               if (is_x || !has_room) mode_in = MODE_IDLE;
            end
            MODE_DUR: begin
               if (is_x) mode_in = MODE_IDLE;
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   // job issue
   always_comb begin
      job_push       = 1'b0;
      job            = '0;
      job.op         = JOB_FAIL;
      job.color      = color_code(rx_byte);
      job.digits     = digits_ff;
      job.seq_len    = text_len_ff;
      job.seq_colors = colors_ff;
      if (byte_valid) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (is_color(rx_byte)) begin
                  job_push = 1'b1;
                  job.op   = JOB_COLOR;
               end
            end
            MODE_TIME: begin
               if (is_x) begin
                  job_push = 1'b1;
                  job.op   = (bad_ff || (text_len_ff != FILL_W'(TIME_DIGITS))) ?
                             JOB_FAIL : JOB_TIME;
               end else if (!has_room) begin
                  job_push = 1'b1;
               end
            end
            MODE_SEQ: begin
               if (is_x) begin
                  job_push = 1'b1;
                  job.op   = (bad_ff || (text_len_ff == '0)) ? JOB_FAIL : JOB_SEQ;
               end else if (!has_room) begin
                  job_push = 1'b1;
               end
            end
            default: job_push = 1'b0;
         endcase
      end
   end

   // buffer bookkeeping; text ends at the first zero byte
   always_comb begin
      fill_in      = fill_ff;
      text_len_in  = text_len_ff;
      zero_seen_in = zero_seen_ff;
      bad_in       = bad_ff;
      if (byte_valid && (mode_ff == MODE_IDLE) && is_start) begin
         fill_in      = '0;
         text_len_in  = '0;
         zero_seen_in = 1'b0;
         bad_in       = 1'b0;
      end else if (store_en) begin
         fill_in = fill_ff + 1'b1;
         if (!zero_seen_ff) begin
            if (rx_byte == CH_NUL) begin
               zero_seen_in = 1'b1;
            end else begin
               text_len_in = text_len_ff + 1'b1;
               if (mode_ff == MODE_TIME) begin
                  if (!is_digit(rx_byte) || (text_len_ff >= FILL_W'(TIME_DIGITS)))
                     bad_in = 1'b1;
               end else if (!is_color(rx_byte)) begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         fill_ff      <= '0;
         text_len_ff  <= '0;
         zero_seen_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         text_len_ff  <= text_len_in;
         zero_seen_ff <= zero_seen_in;
         bad_ff       <= bad_in;
      end
   end

   // low nibble of an ASCII digit is its value
   always_ff @(posedge clock) begin
      if (digit_wr) digits_ff[text_len_ff[DIGIT_IDX_W-1:0]] <= rx_byte[3:0];
      if (color_wr) colors_ff[fill_ff[IDX_W-1:0]] <= color_code(rx_byte);
   end

endmodule

// ===== rtl/ulcp_job_queue.sv =====
// Short queue of decoded jobs between the front end and the result sequencer.
// Depends on ulcp_pkg for the job type and depth.
module ulcp_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ulcp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output ulcp_pkg::job_type pop_job,
   output logic             empty
);
   import ulcp_pkg::*;

   job_type               slots_ff [JOB_QUEUE_DEPTH];
   logic [JQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JQ_CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == JQ_CNT_W'(JOB_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JQ_PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JQ_PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_job;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= JQ_CNT_W'(JOB_QUEUE_DEPTH)) else $error("job queue count overrun");

endmodule

// ===== rtl/ulcp_back.sv =====
// Back end: runs one job at a time and emits its results into the output register.
// Depends on ulcp_pkg; owns the time arithmetic, binary-to-decimal unit and color walk.
module ulcp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  ulcp_pkg::job_type job,
   output logic             job_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_char,
   output logic [1:0]       rsp_color,
   output logic [16:0]      rsp_timer_seconds,
   output logic             rsp_last_of_run
);
   import ulcp_pkg::*;

   back_state_type               state_ff, state_in;
   job_type                      job_ff, job_in;
   logic [HMS_W-1:0]             hh_ff, hh_in, mm_ff, mm_in, ss_ff, ss_in;
   logic [SECS_W-1:0]            secs_ff, secs_in;
   logic [SECS_W-1:0]            conv_ff, conv_in;
   logic [DEC_DIGITS-1:0][3:0]   bcd_ff, bcd_in;
   logic [CONV_CNT_W-1:0]        conv_cnt_ff, conv_cnt_in;
   logic [DEC_IDX_W-1:0]         dig_idx_ff, dig_idx_in;
   logic [IDX_W-1:0]             col_idx_ff, col_idx_in;
   logic                         timer_ff, timer_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   kind_type                     rsp_kind_ff;
   logic [7:0]                   rsp_char_ff;
   logic [1:0]                   rsp_color_ff;
   logic [SECS_W-1:0]            rsp_secs_ff;
   logic                         rsp_last_ff;

   logic                         out_room;
   logic                         rsp_fire;
   logic                         range_bad;
   logic                         conv_done;
   logic                         last_color;
   logic [SECS_W-1:0]            secs_calc;
   logic [DEC_DIGITS-1:0][3:0]   bcd_adj;
   logic [DEC_IDX_W-1:0]         lead_idx;

   logic                         emit_valid;
   kind_type                     emit_kind;
   logic [7:0]                   emit_char;
   logic [1:0]                   emit_color;
   logic [SECS_W-1:0]            emit_secs;
   logic                         emit_last;

   assign rsp_fire   = rsp_pop && rsp_valid_ff;
   assign out_room   = !rsp_valid_ff || rsp_pop;
   assign range_bad  = (hh_ff > MAX_HOURS) || (mm_ff > MAX_MINUTES) || (ss_ff > MAX_MINUTES);
   assign conv_done  = (conv_cnt_ff == CONV_CNT_W'(SECS_W - 1));
   assign last_color = ((FILL_W'(col_idx_ff) + FILL_W'(1)) == job_ff.seq_len);
   assign secs_calc  = SECS_W'(hh_ff) * SECS_PER_HOUR + SECS_W'(mm_ff) * SECS_PER_MINUTE +
                       SECS_W'(ss_ff);
   assign job_pop    = (state_ff == B_IDLE) && !job_empty;

   // add three to each decimal digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               case (job.op)
                  JOB_COLOR: state_in = B_ONE;
                  JOB_FAIL:  state_in = B_NEG;
                  JOB_TIME:  state_in = B_SPLIT;
                  JOB_SEQ:   state_in = B_DIG;
                  default:   state_in = B_IDLE;
               endcase
            end
         end
         B_SPLIT: state_in = B_SCALE;
         B_SCALE: state_in = range_bad ? B_NEG : B_CONV;
         B_CONV:  if (conv_done) state_in = B_DIG;
         B_NEG:   if (out_room) state_in = B_DIG;
         B_DIG:   if (out_room && (dig_idx_ff == '0)) state_in = B_X;
         B_X: begin
            if (out_room) begin
               if (timer_ff) state_in = B_TIMER;
               else if (job_ff.op == JOB_SEQ) state_in = B_COLOR;
               else state_in = B_IDLE;
            end
         end
         B_TIMER: if (out_room) state_in = B_IDLE;
         B_COLOR: if (out_room && last_color) state_in = B_IDLE;
         B_ONE:   if (out_room) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // result produced in the current state
   always_comb begin
      emit_valid = 1'b0;
      emit_kind  = KIND_CHAR;
      emit_char  = '0;
      emit_color = '0;
      emit_secs  = '0;
      emit_last  = 1'b0;
      case (state_ff)
         B_NEG: begin
            emit_valid = 1'b1;
            emit_char  = CH_MINUS;
         end
         B_DIG: begin
            emit_valid = 1'b1;
            emit_char  = CH_ZERO + {4'b0, bcd_ff[dig_idx_ff]};
         end
         B_X: begin
            emit_valid = 1'b1;
            emit_char  = CH_X;
            emit_last  = !timer_ff && (job_ff.op != JOB_SEQ);
         end
         B_TIMER: begin
            emit_valid = 1'b1;
            emit_kind  = KIND_TIMER;
            emit_secs  = secs_ff;
            emit_last  = 1'b1;
         end
         B_COLOR: begin
            emit_valid = 1'b1;
            emit_kind  = KIND_COLOR;
            emit_color = job_ff.seq_colors[col_idx_ff];
            emit_last  = last_color;
         end
         B_ONE: begin
            emit_valid = 1'b1;
            emit_kind  = KIND_COLOR;
            emit_color = job_ff.color;
            emit_last  = 1'b1;
         end
         default: emit_valid = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      job_in      = job_ff;
      hh_in       = hh_ff;
      mm_in       = mm_ff;
      ss_in       = ss_ff;
      secs_in     = secs_ff;
      conv_in     = conv_ff;
      bcd_in      = bcd_ff;
      conv_cnt_in = conv_cnt_ff;
      dig_idx_in  = dig_idx_ff;
      col_idx_in  = col_idx_ff;
      timer_in    = timer_ff;
      lead_idx    = '0;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_in     = job;
               bcd_in     = '0;
               dig_idx_in = '0;
               col_idx_in = '0;
               timer_in   = 1'b0;
               if (job.op == JOB_FAIL) bcd_in[0] = FAIL_DIGIT;
            end
         end
         B_SPLIT: begin
            hh_in = HMS_W'(job_ff.digits[0]) * DECIMAL_BASE + HMS_W'(job_ff.digits[1]);
            mm_in = HMS_W'(job_ff.digits[2]) * DECIMAL_BASE + HMS_W'(job_ff.digits[3]);
            ss_in = HMS_W'(job_ff.digits[4]) * DECIMAL_BASE + HMS_W'(job_ff.digits[5]);
         end
         B_SCALE: begin
            bcd_in      = '0;
            dig_idx_in  = '0;
            conv_cnt_in = '0;
            if (range_bad) begin
               bcd_in[0] = RANGE_DIGIT;
            end else begin
               secs_in  = secs_calc;
               conv_in  = secs_calc;
               timer_in = (secs_calc != '0);
            end
         end
         B_CONV: begin
            // shift the adjusted digits up one bit and bring in the next binary bit
            bcd_in      = {bcd_adj[DEC_DIGITS-1][2:0], bcd_adj[DEC_DIGITS-2:0],
                           conv_ff[SECS_W-1]};
            conv_in     = {conv_ff[SECS_W-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + 1'b1;
            for (int i = 0; i < DEC_DIGITS; i++) begin
               if (bcd_in[i] != '0) lead_idx = DEC_IDX_W'(i);
            end
            if (conv_done) dig_idx_in = lead_idx;
         end
         B_DIG: begin
            if (out_room && (dig_idx_ff != '0)) dig_idx_in = dig_idx_ff - 1'b1;
         end
         B_COLOR: begin
            if (out_room && !last_color) col_idx_in = col_idx_ff + 1'b1;
         end
         default: job_in = job_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid && out_room) rsp_valid_in = 1'b1;
      else if (rsp_fire) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      hh_ff       <= hh_in;
      mm_ff       <= mm_in;
      ss_ff       <= ss_in;
      secs_ff     <= secs_in;
      conv_ff     <= conv_in;
      bcd_ff      <= bcd_in;
      conv_cnt_ff <= conv_cnt_in;
      dig_idx_ff  <= dig_idx_in;
      col_idx_ff  <= col_idx_in;
      timer_ff    <= timer_in;
      if (emit_valid && out_room) begin
         rsp_kind_ff  <= emit_kind;
         rsp_char_ff  <= emit_char;
         rsp_color_ff <= emit_color;
         rsp_secs_ff  <= emit_secs;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_out_kind      = rsp_kind_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_color         = rsp_color_ff;
   assign rsp_timer_seconds = rsp_secs_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CONV) |-> (conv_cnt_ff < CONV_CNT_W'(SECS_W)))
      else $error("decimal conversion ran past its last step");

   a_color_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_COLOR) |-> (FILL_W'(col_idx_ff) < job_ff.seq_len))
      else $error("color walk beyond buffered length");

   a_timer_nonzero_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_TIMER)) |-> ((rsp_secs_ff != '0) && rsp_last_ff))
      else $error("timer start with zero seconds or not last");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff != B_IDLE))
      else $error("job taken but sequencer stayed idle");

endmodule

// ===== rtl/uart_led_command_parser.sv =====
// Top level of the serial LED command parser: front decoder, job queue, result sequencer.
// Depends on ulcp_pkg, ulcp_front, ulcp_job_queue and ulcp_back.
//
// Takes one received byte per cycle whenever the two-entry job queue has room. Each command
// that answers is handed to the result sequencer, which delivers one result per cycle while
// pop keeps up. A color or a failure answer needs no extra work; a sequence answer walks the
// buffered colors one per cycle (up to 21 results); a time answer takes the job, splits the
// digits, scales them to seconds and, unless the time is out of range, runs the bit-serial
// binary-to-decimal converter over the 17-bit seconds value before its first character.
// Full rises only when two answered commands wait behind the one in progress.
module uart_led_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_char,
   output logic [1:0]  rsp_color,
   output logic [16:0] rsp_timer_seconds,
   output logic        rsp_last_of_run
);
   import ulcp_pkg::*;

   logic    byte_valid;
   logic    job_push;
   logic    job_pop;
   logic    job_empty;
   job_type front_job;
   job_type queued_job;

   assign byte_valid = req_push && !req_full;

   ulcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .job_push   (job_push),
      .job        (front_job)
   );

   ulcp_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (job_pop),
      .pop_job  (queued_job),
      .empty    (job_empty)
   );

   ulcp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (job_empty),
      .job               (queued_job),
      .job_pop           (job_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_color         (rsp_color),
      .rsp_timer_seconds (rsp_timer_seconds),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
